### src/per_flow_interval_count_stats_unit_assert.svh
// Assertion macros used by the checker file.
`ifndef PER_FLOW_INTERVAL_COUNT_STATS_UNIT_ASSERT_SVH
`define PER_FLOW_INTERVAL_COUNT_STATS_UNIT_ASSERT_SVH

// Implication checked on every clock edge outside reset.
`define PFIC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication checked on every clock edge outside reset.
`define PFIC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### src/pfic_pkg.sv
// ----------------------------------------------------------------------------
// pfic_pkg
// Shared types and constants of the per-flow interval count statistics unit.
// ----------------------------------------------------------------------------
`default_nettype none
package pfic_pkg;

    localparam int ROW_BITS  = 10;
    localparam int NROWS     = 1 << ROW_BITS;
    localparam int RIDX_W    = (ROW_BITS > 0) ? ROW_BITS : 1;
    localparam int ABITS_W   = 4;

    localparam logic [0:0] REG_INTERVAL_US = 1'b0;
    localparam logic [0:0] REG_AGG_BITS    = 1'b1;

    // Classified packet passed from front to back.
    typedef struct packed {
        logic              ok;
        logic [RIDX_W-1:0] row;
        logic              rolled;
        logic [15:0]       len;
        logic [31:0]       intervals;
        logic [63:0]       total;
    } job_t;

    // Result handed to the output queue.
    typedef struct packed {
        logic        accepted;
        logic [9:0]  row_used;
        logic        rolled_over;
        logic [31:0] interval_pkts;
        logic [47:0] sum_of_counts;
        logic [63:0] sum_of_squares;
        logic [47:0] row_packets;
        logic [63:0] row_bytes;
        logic [31:0] intervals_closed;
        logic [63:0] total_packets;
    } res_t;

endpackage
`default_nettype wire

### src/pfic_front.sv
// ----------------------------------------------------------------------------
// pfic_front
// Accepts packets, tracks the interval end and classifies each packet.
// ----------------------------------------------------------------------------
`default_nettype none
module pfic_front
    import pfic_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         take,
    input  wire logic [63:0]  timestamp_us,
    input  wire logic [31:0]  aggregate_id,
    input  wire logic [15:0]  packet_length,
    input  wire logic [31:0]  interval_us,
    input  wire logic [3:0]   agg_bits,
    output job_t              job
);

    logic [63:0] end_reg;
    logic        armed_reg;
    logic [31:0] num_reg;
    logic [63:0] all_reg;
    logic [63:0] end_eff;
    logic [63:0] new_end;
    logic        rolled;
    logic [3:0]  bits;
    logic        ok;

    always_comb
    begin
        new_end = timestamp_us + {32'd0, interval_us};
        end_eff = armed_reg ? end_reg : new_end;
        rolled  = timestamp_us > end_eff;
        bits    = (agg_bits > 4'(ROW_BITS)) ? 4'(ROW_BITS) : agg_bits;
        if (bits == 4'd0)
            ok = 1'b1;
        else
            ok = (aggregate_id >> bits) == 32'd0;
        job.ok        = ok;
        job.row       = (bits == 4'd0) ? '0 : aggregate_id[RIDX_W-1:0];
        job.rolled    = rolled;
        job.len       = packet_length;
        job.intervals = num_reg + {31'd0, rolled};
        job.total     = all_reg + 64'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            end_reg   <= '0;
            armed_reg <= 1'b0;
            num_reg   <= '0;
            all_reg   <= '0;
        end
        else if (take)
        begin
            armed_reg <= 1'b1;
            end_reg   <= rolled ? new_end : end_eff;
            num_reg   <= job.intervals;
            all_reg   <= job.total;
        end
    end

endmodule
`default_nettype wire

### src/pfic_back.sv
// ----------------------------------------------------------------------------
// pfic_back
// Row memories: clear pass, rollover fold sweep and per-packet update.
// ----------------------------------------------------------------------------
`default_nettype none
module pfic_back
    import pfic_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  job_valid,
    input  wire job_t  job,
    output logic       job_take,
    output logic       res_valid,
    output res_t       res,
    input  wire logic  res_take
);

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_FRD   = 6'b000100,
        S_FWR   = 6'b001000,
        S_RD    = 6'b010000,
        S_WR    = 6'b100000
    } state_t;

    logic [31:0] cnt_mem [NROWS];
    logic [47:0] sum_mem [NROWS];
    logic [63:0] sq_mem  [NROWS];
    logic [47:0] pk_mem  [NROWS];
    logic [63:0] by_mem  [NROWS];

    state_t state_reg, state_next;
    logic [ROW_BITS:0] idx_reg, idx_next;
    job_t job_reg;
    logic [31:0] cnt_q;
    logic [47:0] sum_q, pk_q;
    logic [63:0] sq_q, by_q;
    logic [63:0] sq_prod;
    logic        out_v_reg;
    res_t        res_reg;
    logic [RIDX_W-1:0] addr;
    logic        we_clr, we_fold, we_upd;
    logic        load;

    assign res_valid = out_v_reg;
    assign res       = res_reg;
    assign addr      = (state_reg == S_RD || state_reg == S_WR) ? job_reg.row
                                                                : idx_reg[RIDX_W-1:0];
    assign load      = (state_reg == S_IDLE) && job_valid && !out_v_reg;
    assign job_take  = load;
    assign we_clr    = state_reg == S_CLEAR;
    assign we_fold   = state_reg == S_FWR;
    assign we_upd    = state_reg == S_WR;

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        case (state_reg)
            S_CLEAR:
            begin
                idx_next = idx_reg + 1'b1;
                if (idx_reg == (ROW_BITS+1)'(NROWS - 1))
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                idx_next = '0;
                if (load)
                    state_next = job.rolled ? S_FRD : S_RD;
            end
            S_FRD:   state_next = S_FWR;
            S_FWR:
            begin
                idx_next = idx_reg + 1'b1;
                state_next = (idx_reg == (ROW_BITS+1)'(NROWS - 1)) ? S_RD : S_FRD;
            end
            S_RD:    state_next = S_WR;
            S_WR:    state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // Memory reads are registered.
    always_ff @(posedge clk)
    begin
        cnt_q <= cnt_mem[addr];
        sum_q <= sum_mem[addr];
        sq_q  <= sq_mem[addr];
        pk_q  <= pk_mem[addr];
        by_q  <= by_mem[addr];
    end

    assign sq_prod = {32'd0, cnt_q} * {32'd0, cnt_q};

    always_ff @(posedge clk)
    begin
        if (we_clr)
        begin
            cnt_mem[addr] <= '0;
            sum_mem[addr] <= '0;
            sq_mem[addr]  <= '0;
            pk_mem[addr]  <= '0;
            by_mem[addr]  <= '0;
        end
        else if (we_fold)
        begin
            cnt_mem[addr] <= '0;
            sum_mem[addr] <= sum_q + {16'd0, cnt_q};
            sq_mem[addr]  <= sq_q + sq_prod;
        end
        else if (we_upd && job_reg.ok)
        begin
            cnt_mem[addr] <= cnt_q + 32'd1;
            pk_mem[addr]  <= pk_q + 48'd1;
            by_mem[addr]  <= by_q + {48'd0, job_reg.len};
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            job_reg <= job;
        if (we_upd)
        begin
            res_reg.accepted         <= job_reg.ok;
            res_reg.row_used         <= job_reg.ok ? 10'(job_reg.row) : '0;
            res_reg.rolled_over      <= job_reg.rolled;
            res_reg.interval_pkts    <= job_reg.ok ? cnt_q + 32'd1 : '0;
            res_reg.sum_of_counts    <= job_reg.ok ? sum_q : '0;
            res_reg.sum_of_squares   <= job_reg.ok ? sq_q : '0;
            res_reg.row_packets      <= job_reg.ok ? pk_q + 48'd1 : '0;
            res_reg.row_bytes        <= job_reg.ok ? by_q + {48'd0, job_reg.len} : '0;
            res_reg.intervals_closed <= job_reg.intervals;
            res_reg.total_packets    <= job_reg.total;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            idx_reg   <= '0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            if (we_upd)
                out_v_reg <= 1'b1;
            else if (res_take)
                out_v_reg <= 1'b0;
        end
    end

endmodule
`default_nettype wire

### src/pfic_outq.sv
// ----------------------------------------------------------------------------
// pfic_outq
// Two-entry result queue in front of the pop side.
// ----------------------------------------------------------------------------
`default_nettype none
module pfic_outq
    import pfic_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    input  wire res_t in_res,
    output logic      in_take,
    output logic      empty,
    output res_t      head,
    input  wire logic pop
);

    res_t       ent_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic       push_q, pop_q;

    assign in_take   = in_valid && (cnt_reg != 2'd2);
    assign push_q    = in_take;
    assign empty     = cnt_reg == 2'd0;
    assign pop_q     = pop && !empty;
    assign head      = ent_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push_q)
            ent_reg[wp_reg] <= in_res;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push_q)
                wp_reg <= ~wp_reg;
            if (pop_q)
                rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, push_q} - {1'b0, pop_q};
        end
    end

endmodule
`default_nettype wire

### src/per_flow_interval_count_stats_unit.sv
// ----------------------------------------------------------------------------
// per_flow_interval_count_stats_unit
// Per-flow packet counts per interval with running sum and sum of squares.
// ----------------------------------------------------------------------------
//  channel   | handshake         | payload
//  input     | push / full       | timestamp_us, aggregate_id, packet_length
//  result    | pop / empty       | accepted ... total_packets
//  config    | cfg_valid / ready | cfg_index, cfg_data
//
//  An ordinary packet takes one row read and one row write through
//  single-port row memories, plus queue handoff.
//  A packet that closes an interval first sweeps all 1024 rows to fold them.
//  After reset a pass clears all 1024 rows; one packet is taken and
//  held meanwhile, then full stays high until the pass ends.
//  A stalled pop side absorbs three results (two queued, one in the back end)
//  plus one waiting packet; after that full stays high.
// ----------------------------------------------------------------------------
`default_nettype none
module per_flow_interval_count_stats_unit
    import pfic_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         push,
    output logic              full,
    input  wire logic [63:0]  timestamp_us,
    input  wire logic [31:0]  aggregate_id,
    input  wire logic [15:0]  packet_length,
    output logic              empty,
    input  wire logic         pop,
    output logic              accepted,
    output logic [9:0]        row_used,
    output logic              rolled_over,
    output logic [31:0]       interval_pkts,
    output logic [47:0]       sum_of_counts,
    output logic [63:0]       sum_of_squares,
    output logic [47:0]       row_packets,
    output logic [63:0]       row_bytes,
    output logic [31:0]       intervals_closed,
    output logic [63:0]       total_packets,
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [0:0]   cfg_index,
    input  wire logic [31:0]  cfg_data
);

    logic [31:0] interval_us_reg;
    logic [3:0]  agg_bits_reg;
    job_t        fjob;
    job_t        q_job_reg;
    logic        q_v_reg;
    logic        take;
    logic        job_take;
    logic        res_v;
    res_t        res_b;
    res_t        head;
    logic        res_take;

    // Config writes are taken unchecked; the host must write only when idle.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            interval_us_reg <= '0;
            agg_bits_reg    <= 4'd10;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_INTERVAL_US: interval_us_reg <= cfg_data;
                REG_AGG_BITS:    agg_bits_reg    <= cfg_data[3:0];
                default:         ;
            endcase
        end
    end

    // One-slot queue between front and back.
    assign full = q_v_reg;
    assign take = push && !full;

    pfic_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .take          (take),
        .timestamp_us  (timestamp_us),
        .aggregate_id  (aggregate_id),
        .packet_length (packet_length),
        .interval_us   (interval_us_reg),
        .agg_bits      (agg_bits_reg),
        .job           (fjob)
    );

    always_ff @(posedge clk)
    begin
        if (take)
            q_job_reg <= fjob;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            q_v_reg <= 1'b0;
        else if (take)
            q_v_reg <= 1'b1;
        else if (job_take)
            q_v_reg <= 1'b0;
    end

    pfic_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (q_v_reg),
        .job       (q_job_reg),
        .job_take  (job_take),
        .res_valid (res_v),
        .res       (res_b),
        .res_take  (res_take)
    );

    pfic_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (res_v),
        .in_res    (res_b),
        .in_take   (res_take),
        .empty     (empty),
        .head      (head),
        .pop       (pop)
    );

    assign accepted         = head.accepted;
    assign row_used         = head.row_used;
    assign rolled_over      = head.rolled_over;
    assign interval_pkts    = head.interval_pkts;
    assign sum_of_counts    = head.sum_of_counts;
    assign sum_of_squares   = head.sum_of_squares;
    assign row_packets      = head.row_packets;
    assign row_bytes        = head.row_bytes;
    assign intervals_closed = head.intervals_closed;
    assign total_packets    = head.total_packets;

endmodule
`default_nettype wire

### src/pfic_checker.sv
// ----------------------------------------------------------------------------
// pfic_checker
// Port-level checks of the statistics unit, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "per_flow_interval_count_stats_unit_assert.svh"
module pfic_checker
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        push,
    input wire logic        full,
    input wire logic        empty,
    input wire logic        pop,
    input wire logic        accepted,
    input wire logic [9:0]  row_used,
    input wire logic [31:0] interval_pkts,
    input wire logic [47:0] row_packets
);

    `PFIC_ASSERT_IMPL(a_drop_zero, clk, rst_n, !empty && !accepted, row_used == 10'd0 && interval_pkts == 32'd0)
    `PFIC_ASSERT_IMPL(a_ok_counts, clk, rst_n, !empty && accepted, interval_pkts != 32'd0 || row_packets == 48'd0)
    `PFIC_ASSERT_NEXT(a_push_full, clk, rst_n, push && !full, full)
    `PFIC_ASSERT_NEXT(a_hold, clk, rst_n, !empty && !pop, !empty)

endmodule

bind per_flow_interval_count_stats_unit pfic_checker u_pfic_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .push          (push),
    .full          (full),
    .empty         (empty),
    .pop           (pop),
    .accepted      (accepted),
    .row_used      (row_used),
    .interval_pkts (interval_pkts),
    .row_packets   (row_packets)
);
`default_nettype wire

### tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the per-flow interval count statistics unit: drives
// packets through the push/full queue with random idling, predicts every
// result with a local copy of the row counters and interval state, and
// compares each popped result field by field.
// ----------------------------------------------------------------------------
module tb;
    import pfic_pkg::*;

    localparam int SWEEP_ROWS = 1024;

    logic         clk;
    logic         rst_n;
    logic         push;
    logic         full;
    logic [63:0]  timestamp_us;
    logic [31:0]  aggregate_id;
    logic [15:0]  packet_length;
    logic         empty;
    logic         pop;
    logic         accepted;
    logic [9:0]   row_used;
    logic         rolled_over;
    logic [31:0]  interval_pkts;
    logic [47:0]  sum_of_counts;
    logic [63:0]  sum_of_squares;
    logic [47:0]  row_packets;
    logic [63:0]  row_bytes;
    logic [31:0]  intervals_closed;
    logic [63:0]  total_packets;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [0:0]   cfg_index;
    logic [31:0]  cfg_data;

    per_flow_interval_count_stats_unit u_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .push             (push),
        .full             (full),
        .timestamp_us     (timestamp_us),
        .aggregate_id     (aggregate_id),
        .packet_length    (packet_length),
        .empty            (empty),
        .pop              (pop),
        .accepted         (accepted),
        .row_used         (row_used),
        .rolled_over      (rolled_over),
        .interval_pkts    (interval_pkts),
        .sum_of_counts    (sum_of_counts),
        .sum_of_squares   (sum_of_squares),
        .row_packets      (row_packets),
        .row_bytes        (row_bytes),
        .intervals_closed (intervals_closed),
        .total_packets    (total_packets),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    // Clock: 10 ns period.
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // ------------------------------------------------------------------------
    // Predictor state: a shadow of every row store and the interval tracker.
    // ------------------------------------------------------------------------
    logic [31:0] sh_interval_us;
    logic [3:0]  sh_agg_bits;
    logic [31:0] sh_icount  [SWEEP_ROWS];
    logic [47:0] sh_csum    [SWEEP_ROWS];
    logic [63:0] sh_csq     [SWEEP_ROWS];
    logic [47:0] sh_pkts    [SWEEP_ROWS];
    logic [63:0] sh_bytes   [SWEEP_ROWS];
    logic [63:0] sh_end;
    logic        sh_armed;
    logic [31:0] sh_intervals;
    logic [63:0] sh_all;

    res_t expected_results [$];

    int  fail_count;
    int  popped;
    bit  pop_hold;       // long receiver hold-off requested
    int  idle_pct_push;
    int  idle_pct_pop;
    logic [63:0] now_ts; // running timestamp for random packets

    // Fold one packet into the shadow state and queue its result.
    task automatic predict_packet(input logic [63:0] ts, input logic [31:0] id,
                                  input logic [15:0] len);
        int unsigned bits;
        logic [31:0] row;
        logic        ok;
        logic [63:0] c;
        res_t        r;
        bits = (sh_agg_bits > ROW_BITS) ? ROW_BITS : sh_agg_bits;
        row  = (bits == 0) ? 32'd0 : id;
        ok   = (row < (32'd1 << bits));
        r    = '0;
        if (!sh_armed)
        begin
            sh_end   = ts + {32'd0, sh_interval_us};
            sh_armed = 1'b1;
        end
        if (ts > sh_end)
        begin
            // Sweep covers every row, in use or not.
            for (int i = 0; i < SWEEP_ROWS; i++)
            begin
                c            = {32'd0, sh_icount[i]};
                sh_csum[i]   = sh_csum[i] + c[47:0];
                sh_csq[i]    = sh_csq[i] + c * c;
                sh_icount[i] = '0;
            end
            sh_end        = ts + {32'd0, sh_interval_us};
            sh_intervals  = sh_intervals + 1;
            r.rolled_over = 1'b1;
        end
        sh_all = sh_all + 1;
        if (ok)
        begin
            sh_icount[row[9:0]] = sh_icount[row[9:0]] + 1;
            sh_pkts[row[9:0]]   = sh_pkts[row[9:0]] + 1;
            sh_bytes[row[9:0]]  = sh_bytes[row[9:0]] + {48'd0, len};
            r.accepted       = 1'b1;
            r.row_used       = row[9:0];
            r.interval_pkts  = sh_icount[row[9:0]];
            r.sum_of_counts  = sh_csum[row[9:0]];
            r.sum_of_squares = sh_csq[row[9:0]];
            r.row_packets    = sh_pkts[row[9:0]];
            r.row_bytes      = sh_bytes[row[9:0]];
        end
        r.intervals_closed = sh_intervals;
        r.total_packets    = sh_all;
        expected_results.push_back(r);
    endtask

    // Offer one packet until the block takes it; random idle beforehand.
    // Push stays high afterwards; the next idle cycle or drain() drops it.
    task automatic send_packet(input logic [63:0] ts, input logic [31:0] id,
                               input logic [15:0] len);
        while ($urandom_range(99) < idle_pct_push)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push          <= 1'b1;
        timestamp_us  <= ts;
        aggregate_id  <= id;
        packet_length <= len;
        @(posedge clk);
        while (full)
            @(posedge clk);
        predict_packet(ts, id, len);
    endtask

    // Wait for every expectation, then let any trailing fold settle.
    task automatic drain();
        push <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (2 * SWEEP_ROWS + 20) @(posedge clk);
    endtask

    task automatic write_reg(input logic [0:0] idx, input logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        if (idx == REG_INTERVAL_US)
            sh_interval_us = value;
        else
            sh_agg_bits = value[3:0];
        @(posedge clk);
    endtask

    // Pick an id: mostly inside the rows in use, sometimes anywhere.
    function automatic logic [31:0] pick_id();
        int unsigned bits;
        bits = (sh_agg_bits > ROW_BITS) ? ROW_BITS : sh_agg_bits;
        case ($urandom_range(9))
            0:       return $urandom();
            1:       return (32'd1 << bits) + $urandom_range(3);
            default: return $urandom_range((1 << bits) - 1);
        endcase
    endfunction

    // Advance time mostly in small steps so intervals hold several packets.
    function automatic logic [63:0] next_ts();
        logic [63:0] step;
        case ($urandom_range(19))
            0:       step = {$urandom(), $urandom()};
            1:       step = {32'd0, sh_interval_us} + 64'd1;
            default: step = 64'($urandom_range(8));
        endcase
        return now_ts + step;
    endfunction

    task automatic random_packets(input int n);
        logic [63:0] ts;
        for (int k = 0; k < n; k++)
        begin
            ts     = next_ts();
            now_ts = ts;
            send_packet(ts, pick_id(), 16'($urandom()));
        end
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    task automatic test_directed_extremes();
        // Reset settings: interval 0, full 1024 rows.
        send_packet(64'd100, 32'd0, 16'hFFFF);
        send_packet(64'd100, 32'd1023, 16'd0);      // same time: no close
        send_packet(64'd100, 32'd1024, 16'd5);      // just past the rows: drop
        send_packet(64'd101, 32'hFFFF_FFFF, 16'd1); // drop that still closes
        send_packet(64'd101, 32'd0, 16'h8000);
        send_packet(64'd102, 32'd0, 16'h7FFF);
        send_packet(64'd102, 32'd1023, 16'hFFFF);
        send_packet(64'hFFFF_FFFF_FFFF_FFFF, 32'd5, 16'd9);
        send_packet(64'd0, 32'd5, 16'd9);           // earlier time: no close
        drain();
        // Saturating agg_bits; the end stays at 2^64 - 1, so neither packet closes.
        write_reg(REG_AGG_BITS, 32'hFFFF_FFFF);
        write_reg(REG_INTERVAL_US, 32'hFFFF_FFFF);
        send_packet(64'hFFFF_FFFF_FFFF_FFF0, 32'd512, 16'd3);
        send_packet(64'd7, 32'd512, 16'd3);
        drain();
        // Single row: the id is ignored.
        write_reg(REG_AGG_BITS, 32'd0);
        write_reg(REG_INTERVAL_US, 32'd2);
        send_packet(64'd10, 32'hDEAD_BEEF, 16'd1);
        send_packet(64'd12, 32'd77, 16'd2);
        send_packet(64'd13, 32'd0, 16'd3);
        send_packet(64'd20, 32'd1, 16'd4);
        drain();
        // Two rows: id 1 in range, id 2 dropped.
        write_reg(REG_AGG_BITS, 32'd1);
        send_packet(64'd30, 32'd1, 16'd1);
        send_packet(64'd30, 32'd2, 16'd1);
        send_packet(64'd40, 32'd1, 16'd1);
        drain();
        now_ts = 64'd40;
    endtask

    task automatic test_random_settings();
        for (int ph = 0; ph < 6; ph++)
        begin
            write_reg(REG_AGG_BITS, 32'($urandom_range(15)));
            write_reg(REG_INTERVAL_US, (ph == 5) ? 32'hFFFF_FFFF : $urandom_range(40));
            // Fifth phase sends with no idling at all.
            idle_pct_push = (ph == 4) ? 0 : 15;
            idle_pct_pop  = (ph == 4) ? 0 : 15;
            random_packets(250);
            drain();
        end
        idle_pct_push = 15;
        idle_pct_pop  = 15;
    endtask

    task automatic test_backpressure();
        // Hold pop off long enough that full must rise while packets queue up.
        write_reg(REG_AGG_BITS, 32'd3);
        write_reg(REG_INTERVAL_US, 32'd20);
        pop_hold = 1'b1;
        random_packets(250);
        drain();
    endtask

    // ------------------------------------------------------------------------
    // Result side: random pop with a counted hold-off, check on acceptance.
    // ------------------------------------------------------------------------
    int hold_cycles;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pop         <= 1'b0;
            hold_cycles <= 0;
        end
        else
        begin
            if (pop && !empty)
            begin
                res_t e;
                res_t a;
                a = {accepted, row_used, rolled_over, interval_pkts, sum_of_counts,
                     sum_of_squares, row_packets, row_bytes, intervals_closed,
                     total_packets};
                if (expected_results.size() == 0)
                begin
                    $error("result with no expectation pending");
                    fail_count++;
                end
                else
                begin
                    e = expected_results.pop_front();
                    if (a !== e)
                    begin
                        fail_count++;
                        if (a.accepted !== e.accepted)
                            $error("accepted exp %0d got %0d", e.accepted, a.accepted);
                        if (a.row_used !== e.row_used)
                            $error("row_used exp %0d got %0d", e.row_used, a.row_used);
                        if (a.rolled_over !== e.rolled_over)
                            $error("rolled_over exp %0d got %0d", e.rolled_over,
                                   a.rolled_over);
                        if (a.interval_pkts !== e.interval_pkts)
                            $error("interval_pkts exp %0d got %0d", e.interval_pkts,
                                   a.interval_pkts);
                        if (a.sum_of_counts !== e.sum_of_counts)
                            $error("sum_of_counts exp %0d got %0d", e.sum_of_counts,
                                   a.sum_of_counts);
                        if (a.sum_of_squares !== e.sum_of_squares)
                            $error("sum_of_squares exp %0d got %0d", e.sum_of_squares,
                                   a.sum_of_squares);
                        if (a.row_packets !== e.row_packets)
                            $error("row_packets exp %0d got %0d", e.row_packets,
                                   a.row_packets);
                        if (a.row_bytes !== e.row_bytes)
                            $error("row_bytes exp %0d got %0d", e.row_bytes, a.row_bytes);
                        if (a.intervals_closed !== e.intervals_closed)
                            $error("intervals_closed exp %0d got %0d",
                                   e.intervals_closed, a.intervals_closed);
                        if (a.total_packets !== e.total_packets)
                            $error("total_packets exp %0d got %0d", e.total_packets,
                                   a.total_packets);
                    end
                end
                popped++;
            end
            // A requested hold-off keeps pop low until hold_cycles runs down.
            if (pop_hold && hold_cycles == 0)
            begin
                hold_cycles <= 300;
                pop_hold    = 1'b0;
                pop         <= 1'b0;
            end
            else if (hold_cycles > 0)
            begin
                hold_cycles <= hold_cycles - 1;
                pop         <= 1'b0;
            end
            else
                pop <= ($urandom_range(99) >= idle_pct_pop);
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n         = 1'b0;
        push          = 1'b0;
        timestamp_us  = '0;
        aggregate_id  = '0;
        packet_length = '0;
        cfg_valid     = 1'b0;
        cfg_index     = REG_INTERVAL_US;
        cfg_data      = '0;
        fail_count    = 0;
        popped        = 0;
        pop_hold      = 1'b0;
        idle_pct_push = 15;
        idle_pct_pop  = 15;
        now_ts        = '0;
        sh_interval_us = '0;
        sh_agg_bits    = 4'd10;
        sh_end         = '0;
        sh_armed       = 1'b0;
        sh_intervals   = '0;
        sh_all         = '0;
        for (int i = 0; i < SWEEP_ROWS; i++)
        begin
            sh_icount[i] = '0;
            sh_csum[i]   = '0;
            sh_csq[i]    = '0;
            sh_pkts[i]   = '0;
            sh_bytes[i]  = '0;
        end
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_extremes();
        test_random_settings();
        test_backpressure();

        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // Bound: ~1800 packets, each possibly running a full fold sweep, plus stalls.
    initial
    begin
        #500_000_000;
        $display("status: fail");
        $finish;
    end

endmodule
